/* rtl/core/gsl_pkg.sv */
// ----------------------------------------------------------------------------
// gsl_pkg: shared types and constants of the gradient slope limiter
// Holds the phi format, the queue entry passed from front to back and the
// state encoding of the back end sequencer.
// ----------------------------------------------------------------------------
package gsl_pkg;

	// Values and tolerance share this format, so the ratio does not depend on it.
	localparam int unsigned FracBits = 16;
	localparam int unsigned PhiFrac = 16;
	localparam int unsigned PhiW = PhiFrac + 1;
	localparam logic [PhiW-1:0] PhiOne = PhiW'(1) << PhiFrac;

	// Magnitude of a difference of two 32-bit values needs 33 bits.
	localparam int unsigned MagW = 33;
	// Ratio y as unsigned Q16.16, saturated at 2^31.
	localparam int unsigned YW = 32;

	localparam logic CfgIdxType = 1'b0;
	localparam logic CfgIdxTol = 1'b1;

	// Classified item: either a ratio to compute or a constant term of one.
	typedef struct packed {
		logic            need_div;
		logic            venkat;
		logic [MagW-1:0] num;
		logic [MagW-1:0] den;
		logic            last;
	} gsl_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL,
		ST_DIV2,
		ST_DONE
	} gsl_state_t;

endpackage

/* rtl/core/gsl_front.sv */
// ----------------------------------------------------------------------------
// gsl_front: run capture and classification
// Holds the cell data of the current run, forms d and decides whether the
// item needs a ratio; hands a registered entry to the queue.
// ----------------------------------------------------------------------------
module gsl_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       quad_value,
	input  logic signed [31:0]       cell_value,
	input  logic signed [31:0]       cell_min,
	input  logic signed [31:0]       cell_max,
	input  logic                     last,
	input  logic                     venkat_sel,
	input  logic [15:0]              tolerance,
	output logic                     item_valid,
	input  logic                     item_ready,
	output gsl_pkg::gsl_item_t       item
);
	import gsl_pkg::*;

	logic                run_start_q;
	logic signed [31:0]  cell_q, min_q, max_q;
	logic signed [31:0]  c, mn, mx;
	logic signed [32:0]  d, nmax, nmin, tol;
	logic                valid_q;
	gsl_item_t           item_q, nxt;
	logic                acc;

	assign in_ready = !valid_q || item_ready;
	assign acc = in_valid && in_ready;

	always_comb begin
		c  = run_start_q ? cell_value : cell_q;
		mn = run_start_q ? cell_min : min_q;
		mx = run_start_q ? cell_max : max_q;
		d    = 33'(quad_value) - 33'(c);
		nmax = 33'(mx) - 33'(c);
		nmin = 33'(mn) - 33'(c);
		tol  = 33'($signed({1'b0, tolerance}));
		nxt.venkat = venkat_sel;
		nxt.last = last;
		nxt.need_div = 1'b0;
		nxt.num = '0;
		nxt.den = '0;
		if (d > tol) begin
			nxt.den = d;
			// negative or zero numerator gives ratio zero
			nxt.need_div = 1'b1;
			nxt.num = (nmax > 0) ? nmax : '0;
		end else if (d < -tol) begin
			nxt.den = -d;
			nxt.need_div = 1'b1;
			nxt.num = (nmin < 0) ? -nmin : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
			valid_q <= 1'b0;
			cell_q <= '0;
			min_q <= '0;
			max_q <= '0;
		end else begin
			if (acc) begin
				cell_q <= c;
				min_q <= mn;
				max_q <= mx;
				run_start_q <= last;
				valid_q <= 1'b1;
			end else if (item_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) item_q <= nxt;
	end

	assign item_valid = valid_q;
	assign item = item_q;

endmodule

/* rtl/core/gsl_fifo.sv */
// ----------------------------------------------------------------------------
// gsl_fifo: short queue between front and back
// Two-entry register queue carrying classified items.
// ----------------------------------------------------------------------------
module gsl_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  gsl_pkg::gsl_item_t  wr_item,
	output logic                rd_valid,
	input  logic                rd_ready,
	output gsl_pkg::gsl_item_t  rd_item
);
	import gsl_pkg::*;

	gsl_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

endmodule

/* rtl/core/gsl_div.sv */
// ----------------------------------------------------------------------------
// gsl_div: radix-2 restoring divider
// Unsigned quotient of NW-bit numerator by DW-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module gsl_div #(
	parameter int unsigned NW = 50,
	parameter int unsigned DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign diff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				r_q <= diff;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;

endmodule

/* rtl/core/gsl_back.sv */
// ----------------------------------------------------------------------------
// gsl_back: term evaluation and running minimum
// Sequences the shared divider for y and the Venkatakrishnan quotient,
// keeps the running minimum and presents phi in an output register.
// ----------------------------------------------------------------------------
module gsl_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  gsl_pkg::gsl_item_t                item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gsl_pkg::PhiW-1:0]          phi
);
	import gsl_pkg::*;

	localparam int unsigned DivNW = 51;
	localparam int unsigned DivDW = 50;
	localparam logic [YW-1:0] YMax = YW'(1) << 31;
	localparam logic [YW-1:0] YTwo = YW'(2) << PhiFrac;

	gsl_state_t     st_q, st_d;
	gsl_item_t      cur_q;
	logic [YW-1:0]  y_q;
	logic [63:0]    ysq_q;
	logic [PhiW-1:0] run_q, term;
	logic           take, fin, load_out;
	logic           dv_start, dv_start_q, dv_done;
	logic [DivNW-1:0] dv_num, dv_quo;
	logic [DivDW-1:0] dv_den;
	logic [DivNW-1:0] yq;
	logic [YW-1:0]  ysat;
	logic [51:0]    nsum, dsum;
	logic           ovalid_q;
	logic [PhiW-1:0] phi_q;
	logic [PhiW-1:0] newmin;

	assign item_ready = (st_q == ST_IDLE);
	assign take = item_valid && item_ready;

	assign yq = dv_quo;
	assign ysat = (yq > DivNW'(YMax)) ? YMax : yq[YW-1:0];
	assign nsum = 52'(ysq_q) + (52'(y_q) << (PhiFrac + 1));
	assign dsum = 52'(ysq_q) + (52'(y_q) << PhiFrac) + (52'(2) << (2 * PhiFrac));

	always_comb begin
		st_d = st_q;
		dv_start = 1'b0;
		dv_num = '0;
		dv_den = '0;
		fin = 1'b0;
		term = PhiOne;
		unique case (st_q)
			ST_IDLE: if (take) st_d = ST_DIV1;
			ST_DIV1: begin
				if (!cur_q.need_div) begin
					fin = 1'b1;
				end else if (!dv_start_q) begin
					dv_start = 1'b1;
					dv_num = DivNW'(cur_q.num) << PhiFrac;
					dv_den = DivDW'(cur_q.den);
				end else if (dv_done) begin
					st_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!cur_q.venkat) begin
					term = (y_q > YW'(PhiOne)) ? PhiOne : y_q[PhiW-1:0];
					fin = 1'b1;
				end else if (y_q >= YTwo) begin
					fin = 1'b1;
				end else begin
					// y < 2 keeps nsum below 2^35, so the shifted numerator fits 51 bits
					dv_start = 1'b1;
					dv_num = DivNW'(nsum[34:0]) << PhiFrac;
					dv_den = DivDW'(dsum);
					st_d = ST_DIV2;
				end
			end
			ST_DIV2: if (dv_done) begin
				term = (yq > DivNW'(PhiOne)) ? PhiOne : yq[PhiW-1:0];
				fin = 1'b1;
			end
			ST_DONE: if (!ovalid_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (fin) st_d = (cur_q.last && ovalid_q && !out_ready) ? ST_DONE : ST_IDLE;
	end

	assign newmin = (term < run_q) ? term : run_q;
	// load the output register on a finished last item or from the wait state
	assign load_out = (fin && cur_q.last && !(ovalid_q && !out_ready)) ||
		(st_q == ST_DONE && !ovalid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			run_q <= PhiOne;
			ovalid_q <= 1'b0;
			dv_start_q <= 1'b0;
		end else begin
			st_q <= st_d;
			dv_start_q <= (st_q == ST_DIV1) && (dv_start || dv_start_q) && !dv_done;
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (load_out) run_q <= PhiOne;
			else if (fin) run_q <= newmin;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= item;
		if (st_q == ST_DIV1 && dv_done) begin
			y_q <= ysat;
			ysq_q <= 64'(ysat) * 64'(ysat);
		end
		if (load_out) phi_q <= (st_q == ST_DONE) ? run_q : newmin;
	end

	gsl_div #(.NW(DivNW), .DW(DivDW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	assign out_valid = ovalid_q;
	assign phi = phi_q;

endmodule

/* rtl/core/gradient_slope_limiter.sv */
// ----------------------------------------------------------------------------
// gradient_slope_limiter: per-cell Barth-Jespersen / Venkatakrishnan limiter
// Streams quadrature values of a cell run and returns phi on the last one.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): one quadrature value per transfer; the
//   first transfer of a run also carries cell_value, cell_min and cell_max.
//   last marks the run's final transfer, which yields one phi transfer on
//   the out channel (out_valid/out_ready).
//   Config: cfg_we with cfg_index 0 selects the formula, 1 sets tolerance.
//   An item needing a ratio takes one 51-step division on the shared
//   radix-2 divider, and with Venkatakrishnan a second one while y is
//   below two; dead-band items take none. The back end takes one item
//   at a time and so sets the throughput.
//   The front registers and classifies while the back works; a two-entry
//   queue sits between them.
//   Reset clears the run state: phi accumulator at one, next item opens a run.
//   A stalled receiver holds phi; the back end finishes the next last item
//   and waits until the output register is free.
// ----------------------------------------------------------------------------
module gradient_slope_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            quad_value,
	input  logic signed [31:0]            cell_value,
	input  logic signed [31:0]            cell_min,
	input  logic signed [31:0]            cell_max,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsl_pkg::PhiW-1:0]      phi,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [15:0]                   cfg_wdata
);
	import gsl_pkg::*;

	logic        type_q;
	logic [15:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= 1'b0;
			tol_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgIdxType: type_q <= cfg_wdata[0];
				CfgIdxTol:  tol_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic      fv, fr, qv, qr;
	gsl_item_t fi, qi;

	gsl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.quad_value(quad_value), .cell_value(cell_value), .cell_min(cell_min),
		.cell_max(cell_max), .last(last), .venkat_sel(type_q),
		.tolerance(tol_q), .item_valid(fv), .item_ready(fr), .item(fi)
	);

	gsl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(fv), .wr_ready(fr),
		.wr_item(fi), .rd_valid(qv), .rd_ready(qr), .rd_item(qi)
	);

	gsl_back u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(qv), .item_ready(qr),
		.item(qi), .out_valid(out_valid), .out_ready(out_ready), .phi(phi)
	);

endmodule

/* rtl/core/gsl_checker.sv */
// ----------------------------------------------------------------------------
// gsl_checker: port-level checks of the gradient slope limiter
// Watches the output channel and the range of phi.
// ----------------------------------------------------------------------------
module gsl_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [gsl_pkg::PhiW-1:0] phi
);
	import gsl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phi))
		else $error("phi dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phi <= PhiOne)
		else $error("phi above one");

	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result during reset");

endmodule

bind gradient_slope_limiter gsl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_ready(out_ready), .phi(phi)
);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gradient slope limiter
// Streams runs of quadrature values under both limiter formulas and several
// dead-band settings. A predictor in the bench computes phi for every run and
// the result checker compares each phi transfer against it in order.
// ----------------------------------------------------------------------------
module tb_top;
	import gsl_pkg::*;

	localparam int unsigned Frac = FracBits;
	localparam int unsigned HoldCycles = 2500;
	localparam int unsigned DrainCycles = 300;
	localparam int unsigned WatchdogLimit = 20000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [31:0]       quad_value;
	logic signed [31:0]       cell_value;
	logic signed [31:0]       cell_min;
	logic signed [31:0]       cell_max;
	logic                     last;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [PhiW-1:0]          phi;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [15:0]              cfg_wdata;

	gradient_slope_limiter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.quad_value (quad_value),
		.cell_value (cell_value),
		.cell_min   (cell_min),
		.cell_max   (cell_max),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.phi        (phi),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Limiter model state, mirrors the block's run state and registers.
	logic            mdl_venkat;
	logic [15:0]     mdl_tol;
	logic [PhiW-1:0] mdl_phi;
	longint          mdl_cell;
	longint          mdl_min;
	longint          mdl_max;
	bit              mdl_open;

	logic [PhiW-1:0] phi_expected[$];
	int              errors = 0;

	// Sender pacing and receiver pressure controls.
	bit  gaps_on;
	bit  stalls_on;
	int  burst_left;
	int  hold_req;
	int  hold_seen = 0;
	int  hold_cnt = 0;
	bit  drain_quiet;

	// Unsigned Q16.16 ratio num/den, zero when the signs disagree.
	function automatic longint slope_ratio(longint num, longint den);
		longint an;
		longint ad;
		longint q;
		if (num == 0 || den == 0)
			return 0;
		if ((num < 0) != (den < 0))
			return 0;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an << Frac) / ad;
		return q > (longint'(1) << 31) ? (longint'(1) << 31) : q;
	endfunction

	function automatic logic [PhiW-1:0] limiter_term(longint y);
		longint n;
		longint d;
		longint t;
		if (!mdl_venkat)
			return y > longint'(PhiOne) ? PhiOne : PhiW'(y);
		if (y >= (longint'(2) << Frac))
			return PhiOne;
		n = y * y + (y << (Frac + 1));
		d = y * y + (y << Frac) + (longint'(2) << (2 * Frac));
		t = (n << Frac) / d;
		return t > longint'(PhiOne) ? PhiOne : PhiW'(t);
	endfunction

	// Advance the model by one accepted quadrature point.
	task automatic predict_point(logic signed [31:0] qv, logic signed [31:0] cv,
			logic signed [31:0] mn, logic signed [31:0] mx, logic lst);
		longint          d;
		longint          tol;
		logic [PhiW-1:0] term;
		term = PhiOne;
		if (mdl_open) begin
			mdl_cell = cv;
			mdl_min = mn;
			mdl_max = mx;
			mdl_open = 1'b0;
		end
		d = longint'(qv) - mdl_cell;
		tol = longint'(mdl_tol);
		if (d > tol)
			term = limiter_term(slope_ratio(mdl_max - mdl_cell, d));
		else if (d < -tol)
			term = limiter_term(slope_ratio(mdl_min - mdl_cell, d));
		if (term < mdl_phi)
			mdl_phi = term;
		if (lst) begin
			phi_expected.push_back(mdl_phi);
			mdl_phi = PhiOne;
			mdl_open = 1'b1;
		end
	endtask

	// Offer one quadrature point; hold it until the transfer completes.
	// Valid stays up afterwards so the next point can follow at once.
	task automatic send_point(logic signed [31:0] qv, logic signed [31:0] cv,
			logic signed [31:0] mn, logic signed [31:0] mx, logic lst);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(8, 40) : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid   <= 1'b1;
		quad_value <= qv;
		cell_value <= cv;
		cell_min   <= mn;
		cell_max   <= mx;
		last       <= lst;
		do
			@(posedge clk);
		while (!in_ready);
		predict_point(qv, cv, mn, mx, lst);
		@(negedge clk);
	endtask

	// Wait until every phi has come back, then let trailing points settle.
	task automatic drain_block();
		in_valid <= 1'b0;
		drain_quiet = 1'b1;
		while (phi_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
		drain_quiet = 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CfgIdxType)
			mdl_venkat = val[0];
		else
			mdl_tol = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 8 << Frac)) - (4 << Frac);
		endcase
	endfunction

	// Offset scaled so most points fall near the band edges, some far out.
	function automatic logic signed [31:0] pick_offset();
		case ($urandom_range(0, 4))
			0: return $signed($urandom_range(0, 4)) - 2;
			1: return $signed($urandom_range(0, 131072)) - 65536;
			2: return $urandom;
			default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		endcase
	endfunction

	// One run: mostly well-formed brackets around the cell value, some
	// inverted or wild brackets. Later points carry noise in the cell fields.
	task automatic send_run(int len);
		logic signed [31:0] cv;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		int                 k;
		cv = pick_value();
		case ($urandom_range(0, 5))
			0: begin
				mn = pick_value();
				mx = pick_value();
			end
			1: begin
				mn = cv + $signed($urandom_range(0, 1 << 18));
				mx = cv - $signed($urandom_range(0, 1 << 18));
			end
			default: begin
				mn = cv - $signed($urandom_range(0, 1 << 18));
				mx = cv + $signed($urandom_range(0, 1 << 18));
			end
		endcase
		for (k = 0; k < len; k++)
			send_point(cv + pick_offset(), k == 0 ? cv : pick_value(),
				k == 0 ? mn : pick_value(), k == 0 ? mx : pick_value(),
				k == len - 1);
	endtask

	task automatic test_directed_barth();
		write_reg(CfgIdxType, 16'h0000);
		write_reg(CfgIdxTol, 16'h0000);
		// single-point run with d inside band of zero: term stays one
		send_point(32'sd100, 32'sd100, 32'sd0, 32'sd200, 1'b1);
		// plain ratio below and above one
		send_point(32'sd300, 32'sd100, 32'sd0, 32'sd200, 1'b0);
		send_point(32'sd150, 32'sd100, 32'sd0, 32'sd200, 1'b1);
		// negative ratio: min above cell, max below cell
		send_point(32'sd500, 32'sd100, 32'sd400, 32'sd50, 1'b0);
		send_point(-32'sd500, 32'sd100, 32'sd400, 32'sd50, 1'b1);
		// ratio saturates at 2^15
		send_point(32'sd1, 32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
		// field extremes on a long run
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		send_point(32'sh0000_0000, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b1);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
		// dead band edges at the widest tolerance
		write_reg(CfgIdxTol, 16'hffff);
		send_point(32'sd65535, 32'sd0, -32'sd5, 32'sd5, 1'b0);
		send_point(-32'sd65535, 32'sd0, -32'sd5, 32'sd5, 1'b0);
		send_point(32'sd65536, 32'sd0, -32'sd5, 32'sd5, 1'b0);
		send_point(-32'sd65536, 32'sd0, -32'sd5, 32'sd5, 1'b1);
	endtask

	task automatic test_directed_venkat();
		write_reg(CfgIdxType, 16'hfffe | 16'h0001);
		write_reg(CfgIdxTol, 16'h0001);
		send_point(32'sd300, 32'sd100, 32'sd0, 32'sd200, 1'b1);
		send_point(32'sd110, 32'sd100, 32'sd0, 32'sd300, 1'b1);
		send_point(32'sd102, 32'sd100, 32'sd0, 32'sd300, 1'b1);
		send_point(32'sd101, 32'sd100, 32'sd0, 32'sd300, 1'b1);
		send_point(32'sd5000, 32'sd100, 32'sd400, 32'sd50, 1'b1);
		send_point(-32'sd1, 32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
		send_point(32'sd170000, 32'sd0, 32'sd0, 32'sd65536, 1'b1);
	endtask

	task automatic test_random_runs(int points);
		int sent;
		int len;
		sent = 0;
		while (sent < points) begin
			len = $urandom_range(0, 4) == 0 ? 1 : $urandom_range(1, 8);
			send_run(len);
			sent += len;
		end
	endtask

	// Receiver holds off while the sender keeps offering points.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req++;
		test_random_runs(40);
		gaps_on = 1'b1;
		// pause the sender until every phi is out
		in_valid <= 1'b0;
		while (phi_expected.size() != 0)
			@(posedge clk);
		@(negedge clk);
		test_random_runs(30);
	endtask

	task automatic test_config_sweep();
		int p;
		for (p = 0; p < 10; p++) begin
			write_reg(CfgIdxType, 16'($urandom));
			case (p % 4)
				0: write_reg(CfgIdxTol, 16'h0000);
				1: write_reg(CfgIdxTol, 16'hffff);
				default: write_reg(CfgIdxTol, $urandom_range(0, 3) == 0 ?
					16'($urandom) : 16'($urandom_range(0, 64)));
			endcase
			gaps_on = p != 3;
			stalls_on = p != 5;
			test_random_runs(180);
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Receiver: long hold-offs on request, otherwise its own stall pattern.
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= HoldCycles;
			out_ready <= 1'b0;
		end else if (stalls_on) begin
			out_ready <= $urandom_range(0, 9) > 3;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check each phi transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (phi_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected phi %0d", $time, phi);
			end else begin
				if (phi !== phi_expected[0]) begin
					errors++;
					$display("%0t: phi mismatch expected %0d actual %0d",
						$time, phi_expected[0], phi);
				end
				void'(phi_expected.pop_front());
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we ||
				(drain_quiet && phi_expected.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		quad_value = '0;
		cell_value = '0;
		cell_min = '0;
		cell_max = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgIdxType;
		cfg_wdata = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		burst_left = 0;
		hold_req = 0;
		drain_quiet = 1'b0;
		mdl_venkat = 1'b0;
		mdl_tol = 16'd1;
		mdl_phi = PhiOne;
		mdl_cell = 0;
		mdl_min = 0;
		mdl_max = 0;
		mdl_open = 1'b1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_barth();
		test_directed_venkat();
		test_backpressure();
		test_config_sweep();

		drain_block();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
